### src/ita_pkg.sv
`timescale 1ns / 1ps

package ita_pkg;

  localparam int VALUE_BITS = 32;
  localparam int IN_W       = 32;
  localparam int CHAR_W     = 8;

  localparam int DEC_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int NUM_SLOTS  = (DEC_DIGITS > OCT_DIGITS) ? DEC_DIGITS : OCT_DIGITS;
  localparam int SLOT_BITS  = NUM_SLOTS * 4;
  localparam int REM_W      = $clog2(NUM_SLOTS + 1);
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h37;

  typedef enum logic [1:0] {
    ACT_CHAR = 2'd0,
    ACT_DEC  = 2'd1,
    ACT_OCT  = 2'd2,
    ACT_HEX  = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    DOP_HOLD,
    DOP_CLEAR,
    DOP_OCT,
    DOP_HEX,
    DOP_DABBLE,
    DOP_SHIFT
  } dig_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAR,
    ST_PREP,
    ST_SIGN,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic negate;
    logic shift;
  } mag_ctrl_t;

  typedef struct packed {
    dig_op_t op;
  } dig_ctrl_t;

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [3:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {4'b0000, d};
    if (d < 4'd10) begin
      return CHAR_ZERO + ext;
    end
    return CHAR_ALPHA + ext;
  endfunction

endpackage

### src/ita_mag.sv
`timescale 1ns / 1ps

module ita_mag (
  input  logic                                 clk,
  input  ita_pkg::mag_ctrl_t                   ctrl,
  input  logic [ita_pkg::IN_W-1:0]             value,
  output logic                                 sign,
  output logic [ita_pkg::VALUE_BITS-1:0]       mag
);

  localparam int VB = ita_pkg::VALUE_BITS;

  logic [63:0]   wide;
  logic [VB-1:0] opnd;
  logic [VB-1:0] neg;
  logic [VB-1:0] mag_r;
  logic [VB-1:0] mag_nxt;

  assign wide = 64'(value);
  assign opnd = wide[VB-1:0];
  assign neg  = ~opnd + {{(VB-1){1'b0}}, 1'b1};
  assign sign = opnd[VB-1];
  assign mag  = mag_r;

  always_comb begin
    mag_nxt = mag_r;
    if (ctrl.load) begin
      mag_nxt = ctrl.negate ? neg : opnd;
    end else if (ctrl.shift) begin
      mag_nxt = {mag_r[VB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
  end

endmodule

### src/ita_digits.sv
`timescale 1ns / 1ps

module ita_digits (
  input  logic                           clk,
  input  ita_pkg::dig_ctrl_t             ctrl,
  input  logic [ita_pkg::VALUE_BITS-1:0] mag,
  output logic [3:0]                     top_digit
);

  localparam int VB = ita_pkg::VALUE_BITS;
  localparam int NS = ita_pkg::NUM_SLOTS;
  localparam int SB = ita_pkg::SLOT_BITS;

  logic [3:0]    slot_r   [NS];
  logic [3:0]    slot_nxt [NS];
  logic [3:0]    adj      [NS];
  logic [SB-1:0] ext;

  assign ext       = {{(SB-VB){1'b0}}, mag};
  assign top_digit = slot_r[NS-1];

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      adj[i] = (slot_r[i] >= 4'd5) ? slot_r[i] + 4'd3 : slot_r[i];
    end
  end

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    case (ctrl.op)
      ita_pkg::DOP_CLEAR: begin
        for (int i = 0; i < NS; i++) begin
          slot_nxt[i] = 4'd0;
        end
      end
      ita_pkg::DOP_OCT: begin
        for (int i = 0; i < NS; i++) begin
          slot_nxt[i] = {1'b0, ext[3*i +: 3]};
        end
      end
      ita_pkg::DOP_HEX: begin
        for (int i = 0; i < NS; i++) begin
          slot_nxt[i] = ext[4*i +: 4];
        end
      end
      ita_pkg::DOP_DABBLE: begin
        slot_nxt[0] = {adj[0][2:0], mag[VB-1]};
        for (int i = 1; i < NS; i++) begin
          slot_nxt[i] = {adj[i][2:0], adj[i-1][3]};
        end
      end
      ita_pkg::DOP_SHIFT: begin
        slot_nxt[0] = 4'd0;
        for (int i = 1; i < NS; i++) begin
          slot_nxt[i] = slot_r[i-1];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

endmodule

### src/integer_to_ascii_formatter_top.sv
`timescale 1ns / 1ps
// Character request: the value is registered and its low byte emitted, then idle.
// Octal / hex: digit slots are loaded, leading zero slots skipped, digits emitted.
// Decimal: a '-' for a negative value, then VALUE_BITS double-dabble shifts (32),
// then the leading-zero skip and the digits.
// The BCD digit register takes the magnitude bit-serially, one bit per shift.
// Reset (rst_n low, synchronous) clears the sequencer and the output valid only.

module integer_to_ascii_formatter_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [ita_pkg::IN_W-1:0]     in_tdata,   // [31:0] value
  input  logic [1:0]                   in_tuser,   // [1:0] action
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [ita_pkg::CHAR_W-1:0]   out_tdata,  // [7:0] out_char
  output logic                         out_tlast   // last
);

  localparam int VB = ita_pkg::VALUE_BITS;
  localparam int NS = ita_pkg::NUM_SLOTS;
  localparam int RW = ita_pkg::REM_W;
  localparam int CW = ita_pkg::BIT_CNT_W;

  ita_pkg::state_t    state_r, state_nxt;
  ita_pkg::act_t      kind_r, kind_nxt;
  logic               neg_r, neg_nxt;
  logic [CW-1:0]      bit_cnt_r, bit_cnt_nxt;
  logic [RW-1:0]      rem_r, rem_nxt;
  logic               out_valid_r;
  logic [7:0]         out_data_r;
  logic               out_last_r;

  ita_pkg::mag_ctrl_t mag_ctrl;
  ita_pkg::dig_ctrl_t dig_ctrl;
  logic               mag_sign;
  logic [VB-1:0]      mag;
  logic [3:0]         top_digit;
  logic               out_free;
  logic               emit;
  logic [7:0]         emit_char;
  logic               emit_last;
  logic               skip_zero;

  ita_mag u_mag (
    .clk   (clk),
    .ctrl  (mag_ctrl),
    .value (in_tdata),
    .sign  (mag_sign),
    .mag   (mag)
  );

  ita_digits u_digits (
    .clk       (clk),
    .ctrl      (dig_ctrl),
    .mag       (mag),
    .top_digit (top_digit)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign skip_zero = (top_digit == 4'd0) && (rem_r != RW'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ita_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (ita_pkg::act_t'(in_tuser) == ita_pkg::ACT_CHAR) ?
                      ita_pkg::ST_CHAR : ita_pkg::ST_PREP;
        end
      end
      ita_pkg::ST_CHAR: begin
        if (out_free) state_nxt = ita_pkg::ST_IDLE;
      end
      ita_pkg::ST_PREP: begin
        if (kind_r == ita_pkg::ACT_DEC) begin
          state_nxt = neg_r ? ita_pkg::ST_SIGN : ita_pkg::ST_CONV;
        end else begin
          state_nxt = ita_pkg::ST_SKIP;
        end
      end
      ita_pkg::ST_SIGN: begin
        if (out_free) state_nxt = ita_pkg::ST_CONV;
      end
      ita_pkg::ST_CONV: begin
        if (bit_cnt_r == '0) state_nxt = ita_pkg::ST_SKIP;
      end
      ita_pkg::ST_SKIP: begin
        if (!skip_zero) state_nxt = ita_pkg::ST_EMIT;
      end
      ita_pkg::ST_EMIT: begin
        if (out_free && rem_r == RW'(1)) state_nxt = ita_pkg::ST_IDLE;
      end
      default: state_nxt = ita_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready       = 1'b0;
    mag_ctrl.load   = 1'b0;
    mag_ctrl.negate = 1'b0;
    mag_ctrl.shift  = 1'b0;
    dig_ctrl.op     = ita_pkg::DOP_HOLD;
    kind_nxt        = kind_r;
    neg_nxt         = neg_r;
    bit_cnt_nxt     = bit_cnt_r;
    rem_nxt         = rem_r;
    emit            = 1'b0;
    emit_char       = ita_pkg::digit_glyph(top_digit);
    emit_last       = 1'b0;
    case (state_r)
      ita_pkg::ST_IDLE: begin
        in_tready       = 1'b1;
        mag_ctrl.negate = (ita_pkg::act_t'(in_tuser) == ita_pkg::ACT_DEC) && mag_sign;
        if (in_tvalid) begin
          mag_ctrl.load = 1'b1;
          kind_nxt      = ita_pkg::act_t'(in_tuser);
          neg_nxt       = mag_ctrl.negate;
        end
      end
      ita_pkg::ST_CHAR: begin
        emit_char = mag[7:0];
        emit_last = 1'b1;
        emit      = out_free;
      end
      ita_pkg::ST_PREP: begin
        case (kind_r)
          ita_pkg::ACT_OCT: dig_ctrl.op = ita_pkg::DOP_OCT;
          ita_pkg::ACT_HEX: dig_ctrl.op = ita_pkg::DOP_HEX;
          default:          dig_ctrl.op = ita_pkg::DOP_CLEAR;
        endcase
        bit_cnt_nxt = CW'(VB - 1);
        rem_nxt     = RW'(NS);
      end
      ita_pkg::ST_SIGN: begin
        emit_char = ita_pkg::CHAR_MINUS;
        emit      = out_free;
      end
      ita_pkg::ST_CONV: begin
        dig_ctrl.op    = ita_pkg::DOP_DABBLE;
        mag_ctrl.shift = 1'b1;
        bit_cnt_nxt    = bit_cnt_r - CW'(1);
      end
      ita_pkg::ST_SKIP: begin
        if (skip_zero) begin
          dig_ctrl.op = ita_pkg::DOP_SHIFT;
          rem_nxt     = rem_r - RW'(1);
        end
      end
      ita_pkg::ST_EMIT: begin
        emit_last = (rem_r == RW'(1));
        if (out_free) begin
          emit        = 1'b1;
          dig_ctrl.op = ita_pkg::DOP_SHIFT;
          rem_nxt     = rem_r - RW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ita_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    neg_r     <= neg_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    rem_r     <= rem_nxt;
    if (emit) begin
      out_data_r <= emit_char;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a request is in progress");

  a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |=> (state_r == ita_pkg::ST_IDLE))
    else $error("request did not end after its last character");

  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ita_pkg::ST_SKIP || state_r == ita_pkg::ST_EMIT) |-> (rem_r != '0))
    else $error("digit count ran out during emission");

  a_dec_digit_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ita_pkg::ST_EMIT && kind_r == ita_pkg::ACT_DEC) |-> (top_digit <= 4'd9))
    else $error("decimal digit out of range");

endmodule
